// ----- hw/rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion helpers shared by the RTL. Each macro uses the clk and
// arst_n of the module that expands it. They expand to nothing for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Checks a property on every rising edge outside reset.
`define HTHQ_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checks that a condition never holds outside reset.
`define HTHQ_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`else

`define HTHQ_ASSERT(label, prop, msg)
`define HTHQ_NEVER(label, cond, msg)

`endif

`endif

// ----- hw/rtl/hthq_pkg.sv -----
// ----------------------------------------------------------------------------
// Heightmap height query package
// Field widths, item kinds and default sizing shared by the channels and core.
// ----------------------------------------------------------------------------
package hthq_pkg;

	localparam int GRID_SIDE_MAX_DEF = 256;

	localparam int INDEX_W  = 16;
	localparam int SAMPLE_W = 8;
	localparam int POS_W    = 17;
	localparam int HEIGHT_W = 16;
	localparam int SIDE_W   = 9;

	typedef enum logic {
		KIND_LOAD  = 1'b0,
		KIND_QUERY = 1'b1
	} kind_t;

endpackage

// ----- hw/rtl/hthq_req_if.sv -----
// ----------------------------------------------------------------------------
// Request channel
// Load and query beats into the height query core.
// ----------------------------------------------------------------------------
interface hthq_req_if;

	logic                                   valid;
	logic                                   ready;
	logic                                   kind;
	logic [hthq_pkg::INDEX_W-1:0]           cell_index;
	logic [hthq_pkg::SAMPLE_W-1:0]          sample_value;
	logic signed [hthq_pkg::POS_W-1:0]      x_pos;
	logic signed [hthq_pkg::POS_W-1:0]      z_pos;

	modport source (
		output valid, kind, cell_index, sample_value, x_pos, z_pos,
		input  ready
	);

	modport sink (
		input  valid, kind, cell_index, sample_value, x_pos, z_pos,
		output ready
	);

endinterface

// ----- hw/rtl/hthq_rsp_if.sv -----
// ----------------------------------------------------------------------------
// Response channel
// Height results out of the height query core, one beat per query.
// ----------------------------------------------------------------------------
interface hthq_rsp_if;

	logic                               valid;
	logic                               ready;
	logic                               in_range;
	logic [hthq_pkg::HEIGHT_W-1:0]      height;

	modport source (
		output valid, in_range, height,
		input  ready
	);

	modport sink (
		input  valid, in_range, height,
		output ready
	);

endinterface

// ----- hw/rtl/heightmap_triangle_height_query_core.sv -----
// ----------------------------------------------------------------------------
// Heightmap triangle height query core
// Holds a square grid of 8-bit height samples and returns the height at an
// 8.8 position, interpolated inside the triangle of the cell that holds it.
//
// Channel   Dir   Beat
// req       in    load (cell_index, sample_value) or query (x_pos, z_pos)
// rsp       out   in_range, height (8.8), one beat per query, none per load
// cfg_*     in    grid_side write, taken on a rising edge with cfg_we high
//
// One beat per cycle in each direction while rsp is not stalled; a query
// result passes the five register stages (accept, address, grid read,
// multiply, sum) in order. Each stage moves on when it is empty or the
// stage after it moves, so bubbles close up and rsp stalls hold without
// loss. Reset clears the stage valids and sets the side to GRID_SIDE_MAX,
// at most 256; the grid is not cleared and holds garbage until loaded. A
// load reaches the grid in the read stage, so later queries always see it.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module heightmap_triangle_height_query_core #(
	parameter int GRID_SIDE_MAX = hthq_pkg::GRID_SIDE_MAX_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	hthq_req_if.sink                      req,
	hthq_rsp_if.source                    rsp,
	input  logic                          cfg_we,
	input  logic [hthq_pkg::SIDE_W-1:0]   cfg_wdata
);

	localparam int DEPTH    = GRID_SIDE_MAX * GRID_SIDE_MAX;
	localparam int AW       = $clog2(DEPTH);
	localparam int SW       = $clog2(GRID_SIDE_MAX + 1);
	localparam int LW       = SW + 8;
	localparam int CMPW     = (LW > 16) ? LW : 16;
	localparam int PW       = (AW > SW + 9) ? AW : SW + 9;
	localparam int WW       = (AW > hthq_pkg::INDEX_W) ? AW : hthq_pkg::INDEX_W;
	localparam int XW       = (SW > hthq_pkg::SIDE_W) ? SW : hthq_pkg::SIDE_W;
	localparam int SIDE_RST = (GRID_SIDE_MAX < 256) ? GRID_SIDE_MAX : 256;
	localparam int IDXC_W   = 32;

	// ------------------------------------------------------------------
	// Side register, clamped on write
	// ------------------------------------------------------------------
	logic [SW-1:0]   side_q;
	logic [SW-1:0]   side_nxt;
	logic [XW-1:0]   cfg_ext;
	logic [CMPW-1:0] limit;

	always_comb begin
		cfg_ext = XW'(cfg_wdata);
		if (cfg_ext < XW'(2)) begin
			side_nxt = SW'(2);
		end else if (cfg_ext > XW'(GRID_SIDE_MAX)) begin
			side_nxt = SW'(GRID_SIDE_MAX);
		end else begin
			side_nxt = cfg_ext[SW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_q <= SW'(SIDE_RST);
		end else if (cfg_we) begin
			side_q <= side_nxt;
		end
	end

	assign limit = CMPW'({side_q - SW'(1), 8'h00});

	// ------------------------------------------------------------------
	// Stage enables
	// ------------------------------------------------------------------
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic en1, en2, en3, en4, en5;

	assign en5 = !v_s5 || rsp.ready;
	assign en4 = !v_s4 || en5;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;

	assign req.ready = en1;

	// ------------------------------------------------------------------
	// Stage 1: accept, range check, split position
	// ------------------------------------------------------------------
	logic            kind_s1, we_s1, inr_s1;
	logic [AW-1:0]   wa_s1;
	logic [7:0]      wd_s1, cx_s1, cz_s1, dx_s1, dz_s1;
	logic            inr_c, we_c;
	logic [WW-1:0]   ci_ext;

	always_comb begin
		inr_c = !req.x_pos[hthq_pkg::POS_W-1] && !req.z_pos[hthq_pkg::POS_W-1]
			&& (CMPW'(req.x_pos[15:0]) < limit) && (CMPW'(req.z_pos[15:0]) < limit);
		we_c   = IDXC_W'(req.cell_index) < IDXC_W'(DEPTH);
		ci_ext = WW'(req.cell_index);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en1) begin
			v_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en1 && req.valid) begin
			kind_s1 <= req.kind;
			we_s1   <= we_c;
			wa_s1   <= ci_ext[AW-1:0];
			wd_s1   <= req.sample_value;
			inr_s1  <= inr_c;
			cx_s1   <= req.x_pos[15:8];
			cz_s1   <= req.z_pos[15:8];
			dx_s1   <= req.x_pos[7:0];
			dz_s1   <= req.z_pos[7:0];
		end
	end

	// ------------------------------------------------------------------
	// Stage 2: row addresses of the two cell rows
	// ------------------------------------------------------------------
	logic            kind_s2, we_s2, inr_s2;
	logic [AW-1:0]   wa_s2, a0_s2, a1_s2;
	logic [7:0]      wd_s2, dx_s2, dz_s2;
	logic [PW-1:0]   a0_c, a1_c;

	always_comb begin
		a0_c = PW'(cz_s1) * PW'(side_q) + PW'(cx_s1);
		a1_c = (PW'(cz_s1) + PW'(1)) * PW'(side_q) + PW'(cx_s1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en2 && v_s1) begin
			kind_s2 <= kind_s1;
			we_s2   <= we_s1;
			wa_s2   <= wa_s1;
			wd_s2   <= wd_s1;
			inr_s2  <= inr_s1;
			dx_s2   <= dx_s1;
			dz_s2   <= dz_s1;
			a0_s2   <= a0_c[AW-1:0];
			a1_s2   <= a1_c[AW-1:0];
		end
	end

	// ------------------------------------------------------------------
	// Stage 3: grid read and write. Two copies of the grid, each with two
	// read ports: one serves the lower cell row, the other the upper row.
	// ------------------------------------------------------------------
	logic [7:0]    grid_a_q [DEPTH];
	logic [7:0]    grid_b_q [DEPTH];
	logic          inr_s3;
	logic [7:0]    dx_s3, dz_s3, h0_s3, h1_s3, h2_s3, h3_s3;
	logic          load_s2, query_s2;

	assign load_s2  = v_s2 && (kind_s2 == hthq_pkg::KIND_LOAD);
	assign query_s2 = v_s2 && (kind_s2 == hthq_pkg::KIND_QUERY);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en3) begin
			v_s3 <= query_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en3 && load_s2 && we_s2) begin
			grid_a_q[wa_s2] <= wd_s2;
			grid_b_q[wa_s2] <= wd_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en3 && query_s2) begin
			h0_s3  <= grid_a_q[a0_s2];
			h2_s3  <= grid_a_q[a0_s2 + AW'(1)];
			h1_s3  <= grid_b_q[a1_s2];
			h3_s3  <= grid_b_q[a1_s2 + AW'(1)];
			inr_s3 <= inr_s2;
			dx_s3  <= dx_s2;
			dz_s3  <= dz_s2;
		end
	end

	// ------------------------------------------------------------------
	// Stage 4: triangle select and the two weighted differences
	// ------------------------------------------------------------------
	logic                inr_s4;
	logic [7:0]          base_s4;
	logic signed [18:0]  pa_s4, pb_s4;
	logic [8:0]          fsum_c, wa_c, wb_c;
	logic signed [8:0]   da_c, db_c;
	logic [7:0]          base_c;
	logic signed [18:0]  pa_c, pb_c;

	always_comb begin
		fsum_c = {1'b0, dx_s3} + {1'b0, dz_s3};
		if (!fsum_c[8]) begin
			// Lower triangle, anchored at the near corner.
			base_c = h0_s3;
			wa_c   = {1'b0, dz_s3};
			wb_c   = {1'b0, dx_s3};
			da_c   = $signed({1'b0, h1_s3}) - $signed({1'b0, h0_s3});
			db_c   = $signed({1'b0, h2_s3}) - $signed({1'b0, h0_s3});
		end else begin
			// Upper triangle, anchored at the far corner.
			base_c = h3_s3;
			wa_c   = 9'd256 - {1'b0, dx_s3};
			wb_c   = 9'd256 - {1'b0, dz_s3};
			da_c   = $signed({1'b0, h1_s3}) - $signed({1'b0, h3_s3});
			db_c   = $signed({1'b0, h2_s3}) - $signed({1'b0, h3_s3});
		end
		pa_c = 19'($signed({1'b0, wa_c}) * da_c);
		pb_c = 19'($signed({1'b0, wb_c}) * db_c);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en4) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en4 && v_s3) begin
			inr_s4  <= inr_s3;
			base_s4 <= base_c;
			pa_s4   <= pa_c;
			pb_s4   <= pb_c;
		end
	end

	// ------------------------------------------------------------------
	// Stage 5: sum, clamp and output register
	// ------------------------------------------------------------------
	logic                          inr_s5;
	logic [hthq_pkg::HEIGHT_W-1:0] height_s5;
	logic signed [19:0]            sum_c;
	logic [hthq_pkg::HEIGHT_W-1:0] height_c;

	always_comb begin
		sum_c = $signed({4'b0000, base_s4, 8'h00}) + 20'(pa_s4) + 20'(pb_s4);
		if (!inr_s4 || sum_c < 20'sd0) begin
			height_c = '0;
		end else if (sum_c > 20'sd65535) begin
			height_c = '1;
		end else begin
			height_c = sum_c[15:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (en5) begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en5 && v_s4) begin
			inr_s5    <= inr_s4;
			height_s5 <= height_c;
		end
	end

	assign rsp.valid    = v_s5;
	assign rsp.in_range = inr_s5;
	assign rsp.height   = height_s5;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	`HTHQ_NEVER(a_height_bound, v_s5 && inr_s5 && (height_s5 > 16'hFF00), "height above full scale")
	`HTHQ_ASSERT(a_s4_hold, v_s4 && inr_s4 && !en5 |=> v_s4 && $stable(pa_s4) && $stable(pb_s4), "stage 4 lost data on stall")
	`HTHQ_ASSERT(a_cell_on_grid, v_s1 && inr_s1 |-> (CMPW'(cx_s1) + CMPW'(1)) < CMPW'(side_q), "in-range cell off grid")

endmodule
